### hdl/card_number_luhn_classifier_core_defines.svh
// Assertion macros for the card number classifier.
`ifndef CARD_NUMBER_LUHN_CLASSIFIER_CORE_DEFINES_SVH
`define CARD_NUMBER_LUHN_CLASSIFIER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define CNLC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("cnlc: implication check failed");

`define CNLC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("cnlc: next-cycle check failed");

`else

`define CNLC_ASSERT_IMP(lbl, clk, rstn, ante, cons)

`define CNLC_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

### hdl/cnlc_pkg.sv
// Shared types, constants and digit helpers for the card number classifier.
package cnlc_pkg;

  localparam int CardW     = 54;
  localparam int ConvBits  = 3;
  localparam int ConvSteps = CardW / ConvBits;
  localparam int BcdDigits = 18;
  localparam int BcdW      = BcdDigits * 4;
  localparam int ScanSteps = BcdDigits / 2;
  localparam int CntW      = 5;
  localparam int PosW      = 4;
  localparam int DigCntW   = 5;
  localparam int LeadW     = 7;

  localparam logic [LeadW-1:0]   DecBase   = 7'd10;
  localparam logic [DigCntW-1:0] LenAmex   = 5'd15;
  localparam logic [DigCntW-1:0] LenLong   = 5'd16;
  localparam logic [DigCntW-1:0] LenShort  = 5'd13;
  localparam logic [LeadW-1:0]   AmexPfxA  = 7'd34;
  localparam logic [LeadW-1:0]   AmexPfxB  = 7'd37;
  localparam logic [LeadW-1:0]   MasterLo  = 7'd51;
  localparam logic [LeadW-1:0]   MasterHi  = 7'd55;
  localparam logic [3:0]         VisaLead  = 4'd4;

  typedef enum logic [1:0] {
    ClsInvalid = 2'd0,
    ClsAmex    = 2'd1,
    ClsMaster  = 2'd2,
    ClsVisa    = 2'd3
  } card_class_e;

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StScan,
    StFin
  } ctl_state_e;

  typedef struct packed {
    logic load;
    logic conv;
    logic scan;
    logic emit;
  } dp_cmd_t;

  function automatic logic [3:0] luhn_dbl(input logic [3:0] d);
    logic [4:0] p;
    begin
      p = {d, 1'b0};
      if (p >= 5'd10) begin
        p = p - 5'd9;
      end
      return p[3:0];
    end
  endfunction

  function automatic logic [3:0] mod10(input logic [4:0] v);
    logic [4:0] r;
    begin
      r = v;
      if (r >= 5'd20) begin
        r = r - 5'd20;
      end else if (r >= 5'd10) begin
        r = r - 5'd10;
      end
      return r[3:0];
    end
  endfunction

endpackage

### hdl/cnlc_ctrl.sv
// Sequencer for the card number classifier: conversion, digit scan, result hand-off.
module cnlc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cnlc_pkg::dp_cmd_t cmd_o
);

  cnlc_pkg::ctl_state_e state_q, state_d;
  logic [cnlc_pkg::CntW-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;
  logic emit_ok;
  logic conv_last, scan_last;

  assign emit_ok   = !out_valid_q || out_ready_i;
  assign conv_last = (cnt_q == cnlc_pkg::CntW'(cnlc_pkg::ConvSteps - 1));
  assign scan_last = (cnt_q == cnlc_pkg::CntW'(cnlc_pkg::ScanSteps - 1));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      cnlc_pkg::StIdle: begin
        cnt_d = '0;
        if (in_valid_i) begin
          state_d = cnlc_pkg::StConv;
        end
      end
      cnlc_pkg::StConv: begin
        if (conv_last) begin
          state_d = cnlc_pkg::StScan;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      cnlc_pkg::StScan: begin
        if (scan_last) begin
          state_d = cnlc_pkg::StFin;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      cnlc_pkg::StFin: begin
        if (emit_ok) begin
          state_d = cnlc_pkg::StIdle;
        end
      end
      default: begin
        state_d = cnlc_pkg::StIdle;
      end
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      cnlc_pkg::StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      cnlc_pkg::StConv: begin
        cmd_o.conv = 1'b1;
      end
      cnlc_pkg::StScan: begin
        cmd_o.scan = 1'b1;
      end
      cnlc_pkg::StFin: begin
        cmd_o.emit = emit_ok;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cnlc_pkg::StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### hdl/cnlc_datapath.sv
// Datapath: binary to BCD conversion, Luhn digit scan and classification.
module cnlc_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cnlc_pkg::dp_cmd_t                cmd_i,
  input  logic [cnlc_pkg::CardW-1:0]       card_number_i,
  output logic [1:0]                       card_class_o,
  output logic [cnlc_pkg::DigCntW-1:0]     digit_count_o,
  output logic                             checksum_ok_o
);

  logic [cnlc_pkg::CardW-1:0]   bin_q, bin_d;
  logic [cnlc_pkg::BcdW-1:0]    bcd_q, bcd_d;
  logic [cnlc_pkg::PosW-1:0]    pos_q, pos_d;
  logic [3:0]                   sum_q, sum_d;
  logic [cnlc_pkg::DigCntW-1:0] count_q, count_d;
  logic [3:0]                   lead1_q, lead1_d;
  logic [cnlc_pkg::LeadW-1:0]   lead2_q, lead2_d;
  logic [3:0]                   prev_hi_q, prev_hi_d;
  logic [1:0]                   cls_q, cls_d;
  logic [cnlc_pkg::DigCntW-1:0] cnt_out_q;
  logic                         ok_q, ok_d;

  logic [3:0] lo_dig, hi_dig;
  logic [cnlc_pkg::DigCntW-1:0] pos_odd, pos_even;

  function automatic logic [cnlc_pkg::BcdW-1:0] dabble(
    input logic [cnlc_pkg::BcdW-1:0]     bcd,
    input logic [cnlc_pkg::ConvBits-1:0] bits
  );
    logic [cnlc_pkg::BcdW-1:0] b;
    begin
      b = bcd;
      for (int s = cnlc_pkg::ConvBits - 1; s >= 0; s--) begin
        for (int k = 0; k < cnlc_pkg::BcdDigits; k++) begin
          if (b[4*k +: 4] >= 4'd5) begin
            b[4*k +: 4] = b[4*k +: 4] + 4'd3;
          end
        end
        b = {b[cnlc_pkg::BcdW-2:0], bits[s]};
      end
      return b;
    end
  endfunction

  assign lo_dig   = bcd_q[3:0];
  assign hi_dig   = bcd_q[7:4];
  assign pos_odd  = {pos_q, 1'b1};
  assign pos_even = {pos_q, 1'b0} + cnlc_pkg::DigCntW'(2);

  always_comb begin
    bin_d     = bin_q;
    bcd_d     = bcd_q;
    pos_d     = pos_q;
    sum_d     = sum_q;
    count_d   = count_q;
    lead1_d   = lead1_q;
    lead2_d   = lead2_q;
    prev_hi_d = prev_hi_q;
    if (cmd_i.load) begin
      bin_d     = card_number_i;
      bcd_d     = '0;
      pos_d     = '0;
      sum_d     = '0;
      count_d   = '0;
      lead1_d   = '0;
      lead2_d   = '0;
      prev_hi_d = '0;
    end else if (cmd_i.conv) begin
      bcd_d = dabble(bcd_q, bin_q[cnlc_pkg::CardW-1 -: cnlc_pkg::ConvBits]);
      bin_d = {bin_q[cnlc_pkg::CardW-cnlc_pkg::ConvBits-1:0], {cnlc_pkg::ConvBits{1'b0}}};
    end else if (cmd_i.scan) begin
      bcd_d = {8'd0, bcd_q[cnlc_pkg::BcdW-1:8]};
      pos_d = pos_q + 1'b1;
      sum_d = cnlc_pkg::mod10({1'b0, sum_q} + {1'b0, lo_dig}
                              + {1'b0, cnlc_pkg::luhn_dbl(hi_dig)});
      prev_hi_d = hi_dig;
      if (hi_dig != 4'd0) begin
        count_d = pos_even;
        lead1_d = hi_dig;
        lead2_d = cnlc_pkg::LeadW'(hi_dig) * cnlc_pkg::DecBase + cnlc_pkg::LeadW'(lo_dig);
      end else if (lo_dig != 4'd0) begin
        count_d = pos_odd;
        lead1_d = lo_dig;
        lead2_d = cnlc_pkg::LeadW'(lo_dig) * cnlc_pkg::DecBase + cnlc_pkg::LeadW'(prev_hi_q);
      end
    end
  end

  always_comb begin
    ok_d  = (sum_q == 4'd0);
    cls_d = cnlc_pkg::ClsInvalid;
    if (ok_d) begin
      if (count_q == cnlc_pkg::LenAmex &&
          (lead2_q == cnlc_pkg::AmexPfxA || lead2_q == cnlc_pkg::AmexPfxB)) begin
        cls_d = cnlc_pkg::ClsAmex;
      end else if (count_q == cnlc_pkg::LenLong &&
                   lead2_q >= cnlc_pkg::MasterLo && lead2_q <= cnlc_pkg::MasterHi) begin
        cls_d = cnlc_pkg::ClsMaster;
      end else if ((count_q == cnlc_pkg::LenShort || count_q == cnlc_pkg::LenLong) &&
                   lead1_q == cnlc_pkg::VisaLead) begin
        cls_d = cnlc_pkg::ClsVisa;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q     <= bin_d;
    bcd_q     <= bcd_d;
    sum_q     <= sum_d;
    count_q   <= count_d;
    lead1_q   <= lead1_d;
    lead2_q   <= lead2_d;
    prev_hi_q <= prev_hi_d;
    if (cmd_i.emit) begin
      cls_q     <= cls_d;
      cnt_out_q <= count_q;
      ok_q      <= ok_d;
    end
  end

  assign card_class_o  = cls_q;
  assign digit_count_o = cnt_out_q;
  assign checksum_ok_o = ok_q;

endmodule

### hdl/card_number_luhn_classifier_core.sv
// Card number classifier: Luhn mod-10 check and AMEX/MASTERCARD/VISA classification.
// Each beat passes through the conversion, scan and finish states in turn, with the
// shift-add-3 converter (3 bits per cycle over 54 bits) and the two-digit-per-cycle scan
// of 18 BCD digits; in_ready_o stays low until idle, so beats do not overlap.
// A finished result waits in the output register; the next beat is taken meanwhile.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops any result.
`include "card_number_luhn_classifier_core_defines.svh"

module card_number_luhn_classifier_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [cnlc_pkg::CardW-1:0]   card_number_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   card_class_o,
  output logic [cnlc_pkg::DigCntW-1:0] digit_count_o,
  output logic                         checksum_ok_o
);

  cnlc_pkg::dp_cmd_t cmd;

  cnlc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd)
  );

  cnlc_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .card_number_i(card_number_i),
    .card_class_o (card_class_o),
    .digit_count_o(digit_count_o),
    .checksum_ok_o(checksum_ok_o)
  );

  `CNLC_ASSERT_NXT(a_busy_after_beat, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `CNLC_ASSERT_IMP(a_class_needs_ok, clk_i, rst_ni, out_valid_o && card_class_o != cnlc_pkg::ClsInvalid, checksum_ok_o)
  `CNLC_ASSERT_IMP(a_amex_len, clk_i, rst_ni, out_valid_o && card_class_o == cnlc_pkg::ClsAmex, digit_count_o == cnlc_pkg::LenAmex)
  `CNLC_ASSERT_IMP(a_visa_len, clk_i, rst_ni, out_valid_o && card_class_o == cnlc_pkg::ClsVisa, digit_count_o == cnlc_pkg::LenShort || digit_count_o == cnlc_pkg::LenLong)

endmodule
